// ===== rtl/mpq_pkg.sv =====
// Shared types and codes for the minimum priority queue.
package mpq_pkg;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  pri;
	} entry_t;

	// running minimum carried down the cell row
	typedef struct packed {
		logic        tok;
		logic        have;
		logic [7:0]  pri;
		logic [15:0] id;
	} scan_t;

endpackage

// ===== rtl/min_priority_queue.sv =====
// Minimum priority queue: cell row with a sequencing controller and registered output.
//
// Holds up to DEPTH-1 entries in arrival order in a row of DEPTH-1 cells. An enqueue
// writes the cell at the tail unless the queue is full; its result then waits in S_FIN
// until the output register is free. A dequeue sends a running minimum down the cell
// row one cell per cycle (ties keep the oldest entry), then shifts the chosen cell and
// all later cells down by one together and passes through S_FIN to the output register.
// A dequeue on an empty queue goes straight to S_FIN. One request is worked on at a
// time; the next is taken once the result has moved into the output register.
module min_priority_queue import mpq_pkg::*; #(
	parameter int DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // ticket_id[15:0], entry_priority[23:16]
	input  logic [0:0]  s_tuser,   // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // served_id[15:0], served_priority[23:16], occupancy[30:24]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int NC = DEPTH - 1;
	localparam logic [IW-1:0] FULL_CNT = IW'(DEPTH - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] fill_q;
	logic [1:0]    res_status_q;
	entry_t        res_entry_q;
	logic          m_valid_q;
	logic [1:0]    m_status_q;
	entry_t        m_entry_q;
	logic [6:0]    m_occ_q;

	logic          req;
	logic          req_deq;
	logic          enq_load;
	logic          scan_start;
	logic          shift;
	entry_t        enq_entry;
	scan_t         scan_head;
	logic [IW+6:0] occ_ext;

	entry_t        cell_entry [NC];
	entry_t        cell_next  [NC];
	scan_t         cell_scan  [NC+1];
	logic [IW-1:0] cell_idx   [NC+1];

	assign s_tready   = state_q == S_IDLE;
	assign req        = s_tvalid && s_tready;
	assign req_deq    = s_tuser[0] == ACT_DEQ;
	assign enq_load   = req && !req_deq && fill_q != FULL_CNT;
	assign scan_start = req && req_deq && fill_q != '0;
	assign shift      = state_q == S_SCAN && cell_scan[NC].tok;
	assign enq_entry  = '{id: s_tdata[15:0], pri: s_tdata[23:16]};

	assign scan_head   = '{tok: scan_start, have: 1'b0, pri: 8'd0, id: 16'd0};
	assign cell_scan[0] = scan_head;
	assign cell_idx[0]  = '0;

	genvar g;
	generate
		for (g = 0; g < NC; g++) begin : g_cell
			if (g == NC - 1) begin : g_tail
				assign cell_next[g] = cell_entry[g];
			end else begin : g_mid
				assign cell_next[g] = cell_entry[g+1];
			end
			mpq_cell #(
				.IW(IW),
				.INDEX(g)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.fill      (fill_q),
				.enq_load  (enq_load),
				.enq_entry (enq_entry),
				.shift     (shift),
				.best_idx  (cell_idx[NC]),
				.next_entry(cell_next[g]),
				.cur_entry (cell_entry[g]),
				.scan_in   (cell_scan[g]),
				.idx_in    (cell_idx[g]),
				.scan_out  (cell_scan[g+1]),
				.idx_out   (cell_idx[g+1])
			);
		end
	endgenerate

	assign occ_ext = {7'd0, fill_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req) begin
						if (scan_start) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
						if (enq_load) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (shift) begin
						fill_q  <= fill_q - 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!m_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			res_entry_q <= '0;
			if (req_deq) begin
				res_status_q <= (fill_q == '0) ? ST_EMPTY : ST_DONE;
			end else begin
				res_status_q <= (fill_q == FULL_CNT) ? ST_FULL : ST_DONE;
			end
		end else if (shift) begin
			res_entry_q <= '{id: cell_scan[NC].id, pri: cell_scan[NC].pri};
		end
		if (state_q == S_FIN && (!m_valid_q || m_tready)) begin
			m_status_q <= res_status_q;
			m_entry_q  <= res_entry_q;
			m_occ_q    <= occ_ext[6:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_occ_q, m_entry_q.pri, m_entry_q.id};
	assign m_tuser  = m_status_q;

endmodule

// ===== rtl/mpq_cell.sv =====
// One storage cell of the queue: holds an entry, forwards the running minimum, shifts down.
module mpq_cell import mpq_pkg::*; #(
	parameter int IW    = 7,
	parameter int INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] fill,
	input  logic          enq_load,
	input  entry_t        enq_entry,
	input  logic          shift,
	input  logic [IW-1:0] best_idx,
	input  entry_t        next_entry,
	output entry_t        cur_entry,
	input  scan_t         scan_in,
	input  logic [IW-1:0] idx_in,
	output scan_t         scan_out,
	output logic [IW-1:0] idx_out
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	entry_t        entry_q;
	scan_t         scan_q;
	logic [IW-1:0] idx_q;
	logic          active;
	logic          take;

	assign active = MY_IDX < fill;
	assign take   = scan_in.tok && active && (!scan_in.have || entry_q.pri < scan_in.pri);

	always_ff @(posedge clk) begin
		if (enq_load && fill == MY_IDX) begin
			entry_q <= enq_entry;
		end else if (shift && MY_IDX >= best_idx) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			idx_q  <= '0;
		end else begin
			scan_q.tok  <= scan_in.tok;
			scan_q.have <= scan_in.have | take;
			scan_q.pri  <= take ? entry_q.pri : scan_in.pri;
			scan_q.id   <= take ? entry_q.id : scan_in.id;
			idx_q       <= take ? MY_IDX : idx_in;
		end
	end

	assign cur_entry = entry_q;
	assign scan_out  = scan_q;
	assign idx_out   = idx_q;

endmodule

// ===== verif/tb_min_priority_queue.sv =====
// Self-checking testbench for the min priority queue: stream driver, reply monitor, model.
`timescale 1ns / 1ps

module tb_min_priority_queue;
	import mpq_pkg::*;

	localparam int DEPTH = 128;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASE_REQUESTS = 615;
	localparam int LOG_CAP = 150;

	typedef struct packed {
		logic        action;
		logic [15:0] id;
		logic [7:0]  pri;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] id;
		logic [7:0]  pri;
		logic [6:0]  occ;
	} reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	request_t pending_requests[$];
	reply_t   awaited_replies[$];

	// queue model
	logic [15:0] held_ids[DEPTH];
	logic [7:0]  held_pris[DEPTH];
	int          held_count = 0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int plan_fill = 0;
	int planned = 0;
	int cycle_count = 0;
	int replies_seen = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit req_taken = 1'b0;

	min_priority_queue #(.DEPTH(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic reply_t serve_request(request_t r);
		reply_t rep;
		int     best;
		int     i;
		rep = '0;
		if (r.action == ACT_ENQ) begin
			if (held_count >= DEPTH - 1) begin
				rep.status = ST_FULL;
			end else begin
				held_ids[held_count] = r.id;
				held_pris[held_count] = r.pri;
				held_count++;
			end
		end else if (held_count == 0) begin
			rep.status = ST_EMPTY;
		end else begin
			best = 0;
			for (i = 1; i < held_count; i++) begin
				if (held_pris[i] < held_pris[best]) begin
					best = i;
				end
			end
			rep.status = ST_DONE;
			rep.id = held_ids[best];
			rep.pri = held_pris[best];
			for (i = best; i + 1 < held_count; i++) begin
				held_ids[i] = held_ids[i + 1];
				held_pris[i] = held_pris[i + 1];
			end
			held_count--;
		end
		rep.occ = held_count[6:0];
		return rep;
	endfunction

	task automatic check_field(input string what, input int unsigned want, input int unsigned got,
			inout bit bad);
		if (want != got) begin
			bad = 1'b1;
			if (mismatches < LOG_CAP) begin
				$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			end
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!s_tvalid || req_taken) begin
			req_taken = 1'b0;
			if (pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= {pending_requests[0].pri, pending_requests[0].id};
				s_tuser <= pending_requests[0].action;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// reply side ready, with one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && replies_seen >= 200) begin
			hold_done = 1'b1;
			hold_left = 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// acceptance and reply monitor
	always @(posedge clk) begin
		reply_t want;
		bit     bad;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			if (arst_n && s_tvalid && s_tready) begin
				awaited_replies.push_back(serve_request(pending_requests[0]));
				pending_requests.pop_front();
				req_taken = 1'b1;
			end
			if (arst_n && m_tvalid && m_tready) begin
				replies_seen++;
				if (awaited_replies.size() == 0) begin
					if (mismatches < LOG_CAP) begin
						$display("%0t: unexpected reply expected none actual %h/%h",
							$time, m_tuser, m_tdata);
					end
					mismatches++;
				end else begin
					want = awaited_replies.pop_front();
					bad = 1'b0;
					check_field("status", want.status, m_tuser, bad);
					check_field("served_id", want.id, m_tdata[15:0], bad);
					check_field("served_priority", want.pri, m_tdata[23:16], bad);
					check_field("occupancy", want.occ, m_tdata[30:24], bad);
					if (bad) begin
						mismatches++;
					end
				end
			end
		end
	end

	task automatic queue_request(input logic act, input logic [15:0] id, input logic [7:0] pri);
		request_t r;
		r.action = act;
		r.id = id;
		r.pri = pri;
		pending_requests.push_back(r);
		planned++;
		if (act == ACT_ENQ) begin
			if (plan_fill < DEPTH - 1) begin
				plan_fill++;
			end
		end else if (plan_fill > 0) begin
			plan_fill--;
		end
	endtask

	task automatic random_enqueue();
		logic [7:0] pri;
		// narrow priority range now and then to force ties
		if ($urandom_range(0, 2) == 0) begin
			pri = 8'($urandom_range(0, 3));
		end else begin
			pri = 8'($urandom_range(0, 255));
		end
		queue_request(ACT_ENQ, 16'($urandom_range(0, 65535)), pri);
	endtask

	task automatic random_dequeue();
		queue_request(ACT_DEQ, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
	endtask

	task automatic plan_segment(input int kind);
		int n;
		int bias;
		case (kind)
			0, 1: begin
				while (plan_fill < DEPTH - 1) begin
					random_enqueue();
				end
				repeat ($urandom_range(1, 3)) random_enqueue();
			end
			2, 3: begin
				while (plan_fill > 0) begin
					random_dequeue();
				end
				repeat ($urandom_range(1, 2)) random_dequeue();
			end
			default: begin
				n = $urandom_range(10, 40);
				bias = $urandom_range(30, 70);
				repeat (n) begin
					if ($urandom_range(0, 99) < bias) begin
						random_enqueue();
					end else begin
						random_dequeue();
					end
				end
			end
		endcase
	endtask

	task automatic plan_directed();
		queue_request(ACT_DEQ, 16'hFFFF, 8'hFF);
		queue_request(ACT_ENQ, 16'h0000, 8'hFF);
		queue_request(ACT_ENQ, 16'hFFFF, 8'h00);
		queue_request(ACT_ENQ, 16'h1234, 8'h00);
		queue_request(ACT_ENQ, 16'h0005, 8'h80);
		repeat (4) queue_request(ACT_DEQ, 16'h0000, 8'h00);
		queue_request(ACT_DEQ, 16'h0000, 8'h00);
		queue_request(ACT_ENQ, 16'h000A, 8'h07);
		queue_request(ACT_ENQ, 16'h000B, 8'h07);
		queue_request(ACT_ENQ, 16'h000C, 8'h07);
		queue_request(ACT_DEQ, 16'hA5A5, 8'h5A);
		queue_request(ACT_ENQ, 16'h000D, 8'h03);
		queue_request(ACT_ENQ, 16'h8001, 8'h01);
		repeat (5) queue_request(ACT_DEQ, 16'h5A5A, 8'hA5);
	endtask

	initial begin
		int phase;
		bit first;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 50;
				end
				1: begin
					tx_idle_pct = 50;
					rx_idle_pct = 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			planned = 0;
			first = (phase == 0);
			if (first) begin
				plan_directed();
			end
			while (planned < PHASE_REQUESTS) begin
				plan_segment(first ? 0 : $urandom_range(0, 9));
				first = 1'b0;
			end
			while (pending_requests.size() != 0 || awaited_replies.size() != 0) begin
				@(posedge clk);
			end
		end
		repeat (DEPTH + 16) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
